@@ rtl/core/cnd_pkg.sv @@
// types, codes and character constants for the cpio newc stream deframer
// no dependencies; used by cnd_fsm and cpio_newc_stream_deframer_top
package cnd_pkg;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_NAME,
        PH_NPAD,
        PH_DATA,
        PH_DPAD,
        PH_END,
        PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HDR  = 3'd0,
        KIND_NAME = 3'd1,
        KIND_NPAD = 3'd2,
        KIND_DATA = 3'd3,
        KIND_DPAD = 3'd4,
        KIND_IDLE = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  header_valid;
        logic  record_last;
        logic  archive_end;
        logic  bad_magic;
    } res_flags_t;

    localparam logic [6:0] HDR_LEN     = 7'd110;
    localparam logic [6:0] MAGIC_LEN   = 7'd6;
    localparam logic [6:0] FSIZE_OFF   = 7'd54;
    localparam logic [6:0] NSIZE_OFF   = 7'd94;
    localparam logic [6:0] HEX_DIGITS  = 7'd8;
    localparam logic [3:0] TRAILER_LEN = 4'd10;
    localparam logic [3:0] NAME_POS_MAX = 4'd11;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h30;
            3'd1:    c = 8'h37;
            3'd2:    c = 8'h30;
            3'd3:    c = 8'h37;
            3'd4:    c = 8'h30;
            3'd5:    c = 8'h31;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h54;
            4'd1:    c = 8'h52;
            4'd2:    c = 8'h41;
            4'd3:    c = 8'h49;
            4'd4:    c = 8'h4C;
            4'd5:    c = 8'h45;
            4'd6:    c = 8'h52;
            4'd7:    c = 8'h21;
            4'd8:    c = 8'h21;
            4'd9:    c = 8'h21;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/cnd_fsm.sv @@
// record walker: phase state machine, header counter, hex size decode,
// name/data counters and trailer match; depends on cnd_pkg
module cnd_fsm #(
    parameter int SIZE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             in_byte,
    output cnd_pkg::res_flags_t    flags,
    output logic [SIZE_BITS-1:0]   file_size,
    output logic [SIZE_BITS-1:0]   name_size
);

    cnd_pkg::phase_t phase_reg, phase_next;
    logic [6:0]           hdr_count_reg, hdr_count_next;
    logic [SIZE_BITS-1:0] accum_reg, accum_next;
    logic [SIZE_BITS-1:0] file_len_reg, file_len_next;
    logic [SIZE_BITS-1:0] name_len_reg, name_len_next;
    logic [SIZE_BITS-1:0] remaining_reg, remaining_next;
    logic [1:0]           align_reg, align_next;
    logic                 trailer_match_reg, trailer_match_next;
    logic [3:0]           name_pos_reg, name_pos_next;
    logic                 error_reg, error_next;

    logic                        magic_bad;
    logic                        hdr_done;
    logic [1:0]                  align_inc;
    logic                        name_hit;
    logic [SIZE_BITS-1:0]        rem_dec;
    logic                        rem_zero;
    logic                        fl_zero;
    logic                        in_fsize;
    logic                        in_nsize;
    logic [7:0]                  hex_adj;
    logic signed [7:0]           hex_s;
    logic signed [SIZE_BITS-1:0] hex_sx;
    logic [SIZE_BITS-1:0]        hex_ext;
    logic [SIZE_BITS-1:0]        accum_base;
    logic                        start_rec;
    logic                        last_c;

    assign magic_bad = (phase_reg == cnd_pkg::PH_HDR) && (hdr_count_reg < cnd_pkg::MAGIC_LEN)
                       && (in_byte != cnd_pkg::magic_char(hdr_count_reg[2:0]));
    assign hdr_done  = hdr_count_reg == (cnd_pkg::HDR_LEN - 7'd1);
    assign align_inc = align_reg + 2'd1;
    assign name_hit  = (phase_reg == cnd_pkg::PH_NAME) && (name_pos_reg == cnd_pkg::TRAILER_LEN)
                       && trailer_match_reg && (in_byte == 8'h00);
    assign rem_dec   = remaining_reg - SIZE_BITS'(1);
    assign rem_zero  = rem_dec == '0;
    assign fl_zero   = file_len_reg == '0;
    assign in_fsize  = (hdr_count_reg >= cnd_pkg::FSIZE_OFF)
                       && (hdr_count_reg < cnd_pkg::FSIZE_OFF + cnd_pkg::HEX_DIGITS);
    assign in_nsize  = (hdr_count_reg >= cnd_pkg::NSIZE_OFF)
                       && (hdr_count_reg < cnd_pkg::NSIZE_OFF + cnd_pkg::HEX_DIGITS);

    // hex digit: letters from 'A' upward, everything else relative to '0'
    assign hex_adj    = (in_byte >= 8'h41) ? in_byte - 8'h37 : in_byte - 8'h30;
    assign hex_s      = hex_adj;
    assign hex_sx     = hex_s;
    assign hex_ext    = (in_byte >= 8'h41) ? SIZE_BITS'(hex_adj) : hex_sx;
    assign accum_base = ((hdr_count_reg == cnd_pkg::FSIZE_OFF)
                         || (hdr_count_reg == cnd_pkg::NSIZE_OFF)) ? '0 : accum_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            cnd_pkg::PH_HDR:
            begin
                if (magic_bad)
                    phase_next = cnd_pkg::PH_ERR;
                else if (hdr_done)
                    phase_next = (name_len_reg == '0) ? cnd_pkg::PH_NPAD : cnd_pkg::PH_NAME;
            end
            cnd_pkg::PH_NAME:
            begin
                if (name_hit)
                    phase_next = cnd_pkg::PH_END;
                else if (rem_zero)
                begin
                    if (align_inc != 2'd0)
                        phase_next = cnd_pkg::PH_NPAD;
                    else
                        phase_next = fl_zero ? cnd_pkg::PH_HDR : cnd_pkg::PH_DATA;
                end
            end
            cnd_pkg::PH_NPAD:
            begin
                if (align_inc == 2'd0)
                    phase_next = fl_zero ? cnd_pkg::PH_HDR : cnd_pkg::PH_DATA;
            end
            cnd_pkg::PH_DATA:
            begin
                if (rem_zero)
                    phase_next = (align_inc == 2'd0) ? cnd_pkg::PH_HDR : cnd_pkg::PH_DPAD;
            end
            cnd_pkg::PH_DPAD:
            begin
                if (align_inc == 2'd0)
                    phase_next = cnd_pkg::PH_HDR;
            end
            cnd_pkg::PH_END,
            cnd_pkg::PH_ERR:
                phase_next = phase_reg;
            default:
                phase_next = cnd_pkg::PH_ERR;
        endcase
    end

    // per-byte outputs
    always_comb
    begin
        last_c = 1'b0;
        flags.header_valid = 1'b0;
        unique case (phase_reg)
            cnd_pkg::PH_HDR:
            begin
                flags.kind = cnd_pkg::KIND_HDR;
                flags.header_valid = hdr_done && !magic_bad;
            end
            cnd_pkg::PH_NAME:
            begin
                flags.kind = cnd_pkg::KIND_NAME;
                last_c = name_hit || (rem_zero && (align_inc == 2'd0) && fl_zero);
            end
            cnd_pkg::PH_NPAD:
            begin
                flags.kind = cnd_pkg::KIND_NPAD;
                last_c = (align_inc == 2'd0) && fl_zero;
            end
            cnd_pkg::PH_DATA:
            begin
                flags.kind = cnd_pkg::KIND_DATA;
                last_c = rem_zero && (align_inc == 2'd0);
            end
            cnd_pkg::PH_DPAD:
            begin
                flags.kind = cnd_pkg::KIND_DPAD;
                last_c = align_inc == 2'd0;
            end
            default:
                flags.kind = cnd_pkg::KIND_IDLE;
        endcase
        flags.record_last = last_c;
        flags.archive_end = phase_next == cnd_pkg::PH_END;
        flags.bad_magic   = error_next;
    end

    assign start_rec = last_c && !name_hit;
    assign file_size = file_len_next;
    assign name_size = name_len_next;

    // counters and decoded sizes
    always_comb
    begin
        hdr_count_next     = hdr_count_reg;
        accum_next         = accum_reg;
        file_len_next      = file_len_reg;
        name_len_next      = name_len_reg;
        remaining_next     = remaining_reg;
        align_next         = align_reg;
        trailer_match_next = trailer_match_reg;
        name_pos_next      = name_pos_reg;
        error_next         = error_reg || magic_bad;

        if (phase_reg == cnd_pkg::PH_HDR && !magic_bad)
        begin
            hdr_count_next = hdr_count_reg + 7'd1;
            align_next     = align_inc;
            accum_next     = accum_base;
            if (in_fsize || in_nsize)
                accum_next = (accum_base << 4) + hex_ext;
            if (hdr_count_reg == cnd_pkg::FSIZE_OFF + cnd_pkg::HEX_DIGITS - 7'd1)
                file_len_next = accum_next;
            if (hdr_count_reg == cnd_pkg::NSIZE_OFF + cnd_pkg::HEX_DIGITS - 7'd1)
                name_len_next = accum_next;
            if (hdr_done && name_len_reg != '0)
                remaining_next = name_len_reg;
        end

        if (phase_reg == cnd_pkg::PH_NAME && !name_hit)
        begin
            align_next     = align_inc;
            remaining_next = rem_dec;
            if (name_pos_reg < cnd_pkg::TRAILER_LEN
                && in_byte != cnd_pkg::trailer_char(name_pos_reg))
                trailer_match_next = 1'b0;
            if (name_pos_reg < cnd_pkg::NAME_POS_MAX)
                name_pos_next = name_pos_reg + 4'd1;
        end

        if (phase_reg == cnd_pkg::PH_NPAD || phase_reg == cnd_pkg::PH_DPAD)
            align_next = align_inc;

        if (phase_reg == cnd_pkg::PH_DATA)
        begin
            align_next     = align_inc;
            remaining_next = rem_dec;
        end

        if (phase_next == cnd_pkg::PH_DATA && phase_reg != cnd_pkg::PH_DATA)
            remaining_next = file_len_reg;

        if (start_rec)
        begin
            hdr_count_next     = '0;
            accum_next         = '0;
            align_next         = 2'd0;
            trailer_match_next = 1'b1;
            name_pos_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= cnd_pkg::PH_HDR;
            hdr_count_reg     <= '0;
            accum_reg         <= '0;
            file_len_reg      <= '0;
            name_len_reg      <= '0;
            remaining_reg     <= '0;
            align_reg         <= 2'd0;
            trailer_match_reg <= 1'b1;
            name_pos_reg      <= '0;
            error_reg         <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            hdr_count_reg     <= hdr_count_next;
            accum_reg         <= accum_next;
            file_len_reg      <= file_len_next;
            name_len_reg      <= name_len_next;
            remaining_reg     <= remaining_next;
            align_reg         <= align_next;
            trailer_match_reg <= trailer_match_next;
            name_pos_reg      <= name_pos_next;
            error_reg         <= error_next;
        end
    end

    a_hdr_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == cnd_pkg::PH_HDR |-> hdr_count_reg < cnd_pkg::HDR_LEN)
        else $error("header counter past header length");

    a_name_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        name_pos_reg <= cnd_pkg::NAME_POS_MAX)
        else $error("name position past saturation");

    a_error_phase: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg == (phase_reg == cnd_pkg::PH_ERR))
        else $error("error flag and error phase disagree");

    a_header_exit: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == cnd_pkg::PH_HDR && hdr_done
        |=> phase_reg == cnd_pkg::PH_NAME || phase_reg == cnd_pkg::PH_NPAD)
        else $error("header end did not move to name or name pad");

endmodule

@@ rtl/core/cpio_newc_stream_deframer_top.sv @@
// top level of the cpio newc stream deframer: stream ports and result register
// depends on cnd_pkg and cnd_fsm
//
// usage:
//   s_axis carries the archive one byte per request in s_axis_tdata[7:0].
//   m_axis returns one request per input byte: the byte, its class in
//   m_axis_tuser, m_axis_tlast on the final byte of each record, and in
//   m_axis_tdata the header_valid pulse, the decoded file and name sizes
//   and the archive_end / bad_magic status bits.
//   m_axis_tvalid rises in the cycle after input acceptance; one byte
//   per cycle is sustained while the receiver takes each result, set by the
//   single state update per byte in cnd_fsm feeding the result register.
//   s_axis_tready is high whenever the result register is empty or is
//   being taken in the same cycle, so a stalled receiver holds its result
//   and stops input only for as long as it stalls.
//   reset puts the walker at the start of a record header with all sizes
//   zero and clears the error and end status; the result register empties.
//   after the trailer name or a bad magic byte every further byte comes
//   back tagged idle.
module cpio_newc_stream_deframer_top #(
    parameter int SIZE_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // in_byte
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // out_byte, header_valid, file_size, name_size, archive_end, bad_magic
    output logic [((11 + 2 * SIZE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [2:0]                m_axis_tuser,   // byte_kind
    output logic                      m_axis_tlast    // record_last
);

    localparam int DATA_BITS = 11 + 2 * SIZE_BITS;
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

    logic                  step;
    cnd_pkg::res_flags_t   flags;
    logic [SIZE_BITS-1:0]  file_size;
    logic [SIZE_BITS-1:0]  name_size;
    logic                  valid_reg;
    logic [TDATA_W-1:0]    tdata_reg, tdata_next;
    logic [2:0]            tuser_reg;
    logic                  tlast_reg;

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    cnd_fsm #(
        .SIZE_BITS (SIZE_BITS)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .in_byte   (s_axis_tdata),
        .flags     (flags),
        .file_size (file_size),
        .name_size (name_size)
    );

    assign tdata_next = TDATA_W'({flags.bad_magic, flags.archive_end, name_size, file_size,
                                  flags.header_valid, s_axis_tdata});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (step)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= flags.kind;
            tlast_reg <= flags.record_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;
    assign m_axis_tlast  = tlast_reg;

    a_idle_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && tuser_reg == cnd_pkg::KIND_IDLE |-> !tlast_reg)
        else $error("idle byte marked as record end");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> tuser_reg <= cnd_pkg::KIND_IDLE)
        else $error("byte class out of range");

    a_hv_is_header: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && tdata_reg[8] |-> tuser_reg == cnd_pkg::KIND_HDR)
        else $error("header_valid on a non-header byte");

endmodule
